FILE: src/fdk_pkg.sv
// Package for the FIFO with duplicate key reject.
// Holds item structs, status and command codes and default sizes; no dependencies.
`timescale 1ns / 1ps

package fdk_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 16;
   localparam int KEY_W  = 32;
   localparam int DATA_W = 32;
   localparam int FILL_W = 5;

   localparam logic CMD_ENQ = 1'b0;
   localparam logic CMD_DEQ = 1'b1;

   typedef enum logic [2:0] {
      ST_ENQ   = 3'd0,
      ST_DUP   = 3'd1,
      ST_FULL  = 3'd2,
      ST_DEQ   = 3'd3,
      ST_EMPTY = 3'd4
   } status_type;

   typedef struct packed {
      logic                      cmd;
      logic signed [KEY_W-1:0]   entry_key;
      logic signed [DATA_W-1:0]  entry_data;
   } req_item_type;

   typedef struct packed {
      status_type                status;
      logic signed [KEY_W-1:0]   out_key;
      logic signed [DATA_W-1:0]  out_data;
      logic [FILL_W-1:0]         fill_count;
      logic                      is_empty;
   } rsp_item_type;

endpackage

FILE: src/fdk_store.sv
// Ring store of key and data pairs: one write port, one registered read port.
// Depends on fdk_pkg.
`timescale 1ns / 1ps

module fdk_store
   import fdk_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [PTR_W-1:0]         wr_addr,
   input  logic signed [KEY_W-1:0]  wr_key,
   input  logic signed [DATA_W-1:0] wr_data,
   input  logic [PTR_W-1:0]         rd_addr,
   output logic signed [KEY_W-1:0]  rd_key,
   output logic signed [DATA_W-1:0] rd_data
);

   logic signed [KEY_W-1:0]  key_mem  [QUEUE_DEPTH];
   logic signed [DATA_W-1:0] data_mem [QUEUE_DEPTH];
   logic signed [KEY_W-1:0]  rd_key_ff;
   logic signed [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]  <= wr_key;
         data_mem[wr_addr] <= wr_data;
      end
      rd_key_ff  <= key_mem[rd_addr];
      rd_data_ff <= data_mem[rd_addr];
   end

   assign rd_key  = rd_key_ff;
   assign rd_data = rd_data_ff;

endmodule

FILE: src/fdk_seq.sv
// Sequencer: pointers, occupancy, key scan with one comparator, result build.
// Depends on fdk_pkg; drives the ports of fdk_store.
`timescale 1ns / 1ps

module fdk_seq
   import fdk_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_item_type             req_item,
   output logic                     res_valid,
   input  logic                     res_ready,
   output rsp_item_type             res_item,
   output logic                     wr_en,
   output logic [PTR_W-1:0]         wr_addr,
   output logic signed [KEY_W-1:0]  wr_key,
   output logic signed [DATA_W-1:0] wr_data,
   output logic [PTR_W-1:0]         rd_addr,
   input  logic signed [KEY_W-1:0]  rd_key,
   input  logic signed [DATA_W-1:0] rd_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DEQ,
      S_RESP
   } state_type;

   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(QUEUE_DEPTH);
   localparam logic [OCC_W-1:0] ONE_OCC  = OCC_W'(1);

   state_type                state_ff, state_in;
   logic signed [KEY_W-1:0]  key_ff, key_in;
   logic signed [DATA_W-1:0] data_ff, data_in;
   logic [PTR_W-1:0]         head_ff, head_in;
   logic [PTR_W-1:0]         tail_ff, tail_in;
   logic [PTR_W-1:0]         scan_ptr_ff, scan_ptr_in;
   logic [OCC_W-1:0]         occ_ff, occ_in;
   logic [OCC_W-1:0]         iss_cnt_ff, iss_cnt_in;
   logic                     cmp_vld_ff, cmp_vld_in;
   rsp_item_type             res_ff, res_in;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      ring_next = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      state_in    = state_ff;
      key_in      = key_ff;
      data_in     = data_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      scan_ptr_in = scan_ptr_ff;
      occ_in      = occ_ff;
      iss_cnt_in  = iss_cnt_ff;
      cmp_vld_in  = 1'b0;
      res_in      = res_ff;
      wr_en       = 1'b0;
      wr_addr     = tail_ff;
      wr_key      = key_ff;
      wr_data     = data_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in  = req_item.entry_key;
               data_in = req_item.entry_data;
               if (req_item.cmd == CMD_ENQ) begin
                  if (occ_ff == '0) begin
                     wr_en    = 1'b1;
                     wr_key   = req_item.entry_key;
                     wr_data  = req_item.entry_data;
                     tail_in  = ring_next(tail_ff);
                     occ_in   = occ_ff + ONE_OCC;
                     res_in   = '{ST_ENQ, '0, '0, FILL_W'(occ_in), 1'b0};
                     state_in = S_RESP;
                  end else begin
                     scan_ptr_in = head_ff;
                     iss_cnt_in  = '0;
                     state_in    = S_SCAN;
                  end
               end else begin
                  if (occ_ff == '0) begin
                     res_in   = '{ST_EMPTY, '0, '0, '0, 1'b1};
                     state_in = S_RESP;
                  end else begin
                     state_in = S_DEQ;
                  end
               end
            end
         end
         S_SCAN: begin
            if (iss_cnt_ff != occ_ff) begin
               cmp_vld_in  = 1'b1;
               scan_ptr_in = ring_next(scan_ptr_ff);
               iss_cnt_in  = iss_cnt_ff + ONE_OCC;
            end
            if (cmp_vld_ff && (rd_key == key_ff)) begin
               res_in   = '{ST_DUP, '0, '0, FILL_W'(occ_ff), 1'b0};
               state_in = S_RESP;
            end else if ((iss_cnt_ff == occ_ff) && !cmp_vld_ff) begin
               if (occ_ff == FULL_OCC) begin
                  res_in = '{ST_FULL, '0, '0, FILL_W'(occ_ff), 1'b0};
               end else begin
                  wr_en   = 1'b1;
                  tail_in = ring_next(tail_ff);
                  occ_in  = occ_ff + ONE_OCC;
                  res_in  = '{ST_ENQ, '0, '0, FILL_W'(occ_in), 1'b0};
               end
               state_in = S_RESP;
            end
         end
         S_DEQ: begin
            head_in  = ring_next(head_ff);
            occ_in   = occ_ff - ONE_OCC;
            res_in   = '{ST_DEQ, rd_key, rd_data, FILL_W'(occ_in), occ_ff == ONE_OCC};
            state_in = S_RESP;
         end
         S_RESP: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         head_ff    <= '0;
         tail_ff    <= '0;
         occ_ff     <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         occ_ff     <= occ_in;
         cmp_vld_ff <= cmp_vld_in;
      end
      key_ff      <= key_in;
      data_ff     <= data_in;
      scan_ptr_ff <= scan_ptr_in;
      iss_cnt_ff  <= iss_cnt_in;
      res_ff      <= res_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_RESP);
   assign res_item  = res_ff;
   assign rd_addr   = (state_ff == S_SCAN) ? scan_ptr_ff : head_ff;

endmodule

FILE: src/fifo_with_duplicate_key_reject.sv
// Bounded FIFO of signed key and data pairs that rejects an enqueue whose key is
// already held, or that finds the queue full, and reports an empty dequeue by status.
// One item is handled at a time. An enqueue scans the held keys through one
// comparator fed by the store's single registered read port; an enqueue into an
// empty queue skips the scan. Every item yields one result with status, the
// dequeued pair (zero otherwise), the fill count after the operation and an empty
// flag. The result sits in an output register, so the next item is accepted while
// it waits; a further result that finds that register still full holds the block
// until it drains. Depends on fdk_pkg, fdk_store and fdk_seq.
`timescale 1ns / 1ps

module fifo_with_duplicate_key_reject
   import fdk_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   logic                     wr_en;
   logic [PTR_W-1:0]         wr_addr;
   logic [PTR_W-1:0]         rd_addr;
   logic signed [KEY_W-1:0]  wr_key;
   logic signed [KEY_W-1:0]  rd_key;
   logic signed [DATA_W-1:0] wr_data;
   logic signed [DATA_W-1:0] rd_data;
   logic                     res_valid;
   logic                     res_ready;
   rsp_item_type             res_item;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_item_type             rsp_item_ff, rsp_item_in;

   fdk_store #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_key (wr_key),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_key (rd_key),
      .rd_data(rd_data)
   );

   fdk_seq #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_item (req_item),
      .res_valid(res_valid),
      .res_ready(res_ready),
      .res_item (res_item),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_key   (wr_key),
      .wr_data  (wr_data),
      .rd_addr  (rd_addr),
      .rd_key   (rd_key),
      .rd_data  (rd_data)
   );

   // output register loads when empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_item_in = res_item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule
